>>> hw/rtl/f2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// f2d_pkg
// Shared types and constants for the binary32 to decimal converter.
// ----------------------------------------------------------------------------
package f2d_pkg;

  localparam int unsigned MAX_SCALE = 28;
  localparam int unsigned SC_W      = 5;
  localparam int unsigned SIG_W     = 53;
  localparam int unsigned EXP_W     = 9;
  localparam int unsigned MAN_W     = 64;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned NCHUNK    = MAN_W / CHUNK_W;

  // float magnitude pattern of 2^96; anything above is out of range
  localparam logic [30:0] MAG_LIMIT = 31'h6F800000;

  // 1e-10 as a double: significand * 2^FRAC_EPS_EXP
  localparam logic [SIG_W-1:0] FRAC_EPS_SIG = 53'h1B7CDFD9D7BDBB;
  localparam int               FRAC_EPS_EXP = -86;

  // n / 10 == (n * DIV10_RECIP) >> DIV10_SHIFT for all n < 2^32
  localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_MUL1,
    ST_MUL2,
    ST_RND,
    ST_CHK,
    ST_DIV,
    ST_STRIP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic norm;
    logic mul;
    logic rnd;
    logic div_clr;
    logic div_step;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic zero;
    logic m_top;
    logic lt_one;
    logic frac_big;
    logic sc_max;
    logic sc_zero;
    logic rem_zero;
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/float_to_decimal96_convert_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// float_to_decimal96_convert_top
// binary32 pattern in, decimal (mantissa / 10^scale, sign) out.
// ----------------------------------------------------------------------------
// Input word: in_float_bits, taken when in_valid && in_ready.
// Output word: out_error, out_mantissa, out_scale, out_negative, held in an
// output register and presented with out_valid until out_ready.
// One word at a time: in_ready is high only while the sequencer is idle.
// Work per word, from accept to out_valid:
//   NaN/inf/too large/zero go straight to the result; subnormal inputs are
//   first shifted left by up to 22 bit positions; then up to 28 x10 steps,
//   one round step, and for each stripped trailing zero (at most 28) a check,
//   4 chunk steps of the divide-by-ten unit and a commit.
// The result register frees the sequencer: a new word is accepted as soon
// as the previous result is loaded, even if the receiver stalls; a further
// result waits in the final state until the register is taken.
// Reset (rst_n low, synchronous) returns to idle with out_valid low.
// ----------------------------------------------------------------------------
module float_to_decimal96_convert_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [31:0]                   in_float_bits,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_error,
  output logic [f2d_pkg::MAN_W-1:0]          out_mantissa,
  output logic [f2d_pkg::SC_W-1:0]           out_scale,
  output logic                               out_negative
);

  f2d_pkg::cmd_t    cmd;
  f2d_pkg::status_t sts;

  f2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  f2d_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_float_bits (in_float_bits),
    .out_error     (out_error),
    .out_mantissa  (out_mantissa),
    .out_scale     (out_scale),
    .out_negative  (out_negative)
  );

endmodule
`default_nettype wire

>>> hw/rtl/f2d_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// f2d_datapath
// Double-precision significand/exponent registers with a x10 step, rounding,
// a chunked divide-by-ten unit for zero stripping, and the result register.
// ----------------------------------------------------------------------------
module f2d_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire f2d_pkg::cmd_t            cmd,
  output f2d_pkg::status_t              sts,
  input  wire logic [31:0]              in_float_bits,
  output logic                          out_error,
  output logic [f2d_pkg::MAN_W-1:0]     out_mantissa,
  output logic [f2d_pkg::SC_W-1:0]      out_scale,
  output logic                          out_negative
);

  localparam int unsigned SW = f2d_pkg::SIG_W;
  localparam int unsigned EW = f2d_pkg::EXP_W;
  localparam int unsigned MW = f2d_pkg::MAN_W;
  localparam int unsigned CW = f2d_pkg::CHUNK_W;

  logic [SW-1:0]        m_r, m_nxt;
  logic signed [EW-1:0] x_r, x_nxt;
  logic [f2d_pkg::SC_W-1:0] sc_r, sc_nxt;
  logic                 neg_r, neg_nxt;
  logic                 err_r, err_nxt;
  logic                 zero_r, zero_nxt;
  logic [MW-1:0]        man_r, man_nxt;
  logic [MW-1:0]        quot_r, quot_nxt;
  logic [3:0]           rem_r, rem_nxt;
  logic [1:0]           cnt_r, cnt_nxt;

  // load decode
  logic [30:0] mag;
  logic [7:0]  ef;
  assign mag = in_float_bits[30:0];
  assign ef  = in_float_bits[30:23];

  // x10 with round to nearest even
  logic [SW+3:0] prod10;
  logic [SW-1:0] kept;
  logic          g_bit, st_bit, inc10;
  logic [SW:0]   sum10;
  logic [2:0]    sh10;
  always_comb begin
    prod10 = ({4'b0, m_r} << 3) + ({4'b0, m_r} << 1);
    if (prod10[SW+3]) begin
      kept   = prod10[SW+3:4];
      g_bit  = prod10[3];
      st_bit = |prod10[2:0];
      sh10   = 3'd4;
    end else begin
      kept   = prod10[SW+2:3];
      g_bit  = prod10[2];
      st_bit = |prod10[1:0];
      sh10   = 3'd3;
    end
    inc10 = g_bit & (st_bit | kept[0]);
    sum10 = {1'b0, kept} + {{SW{1'b0}}, inc10};
  end

  // fraction test against 1e-10
  logic [EW-1:0]   negx;
  logic [SW-1:0]   fmask, fpart, thr;
  logic signed [EW-1:0] thr_sh;
  logic            frac_big;
  always_comb begin
    negx   = EW'(-x_r);
    fmask  = (negx >= EW'(SW)) ? {SW{1'b1}} : ((SW'(1) << negx) - SW'(1));
    fpart  = m_r & fmask;
    thr_sh = x_r - EW'(f2d_pkg::FRAC_EPS_EXP);
    thr    = f2d_pkg::FRAC_EPS_SIG >> thr_sh[EW-2:0];
    frac_big = x_r[EW-1] && !thr_sh[EW-1] && (fpart > thr);
  end

  // final rounding to integer; error if the result reaches 2^64
  logic [SW+MW-1:0] ext;
  logic             r_inc;
  logic [MW-1:0]    r_man;
  logic             r_err;
  always_comb begin
    ext   = {m_r, {MW{1'b0}}} >> negx;
    r_inc = ext[MW-1] & ((|ext[MW-2:0]) | ext[MW]);
    r_err = 1'b0;
    if (x_r[EW-1]) begin
      r_man = MW'(ext[SW+MW-1:MW]) + MW'(r_inc);
    end else if (x_r >= EW'(12)) begin
      r_man = '0;
      r_err = 1'b1;
    end else begin
      r_man = MW'(m_r) << x_r[3:0];
    end
  end

  // divide-by-ten, one 16-bit chunk a step
  logic [CW-1:0] chunk;
  logic [CW+3:0] dv;
  logic [51:0]   dprod;
  logic [CW-1:0] dq;
  logic [CW+3:0] dq10, dr;
  always_comb begin
    case (cnt_r)
      2'd0:    chunk = man_r[63:48];
      2'd1:    chunk = man_r[47:32];
      2'd2:    chunk = man_r[31:16];
      default: chunk = man_r[15:0];
    endcase
    dv    = {rem_r, chunk};
    dprod = 52'(dv) * 52'(f2d_pkg::DIV10_RECIP);
    dq    = dprod[f2d_pkg::DIV10_SHIFT+CW-1:f2d_pkg::DIV10_SHIFT];
    dq10  = ({4'b0, dq} << 3) + ({4'b0, dq} << 1);
    dr    = dv - dq10;
  end

  always_comb begin
    m_nxt    = m_r;
    x_nxt    = x_r;
    sc_nxt   = sc_r;
    neg_nxt  = neg_r;
    err_nxt  = err_r;
    zero_nxt = zero_r;
    man_nxt  = man_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (cmd.load) begin
      neg_nxt  = in_float_bits[31];
      err_nxt  = mag > f2d_pkg::MAG_LIMIT;
      zero_nxt = mag == '0;
      sc_nxt   = '0;
      man_nxt  = '0;
      if (ef != '0) begin
        m_nxt = {1'b1, in_float_bits[22:0], 29'b0};
        x_nxt = EW'({1'b0, ef}) - EW'(179);
      end else begin
        m_nxt = {in_float_bits[22:0], 30'b0};
        x_nxt = -EW'(179);
      end
    end
    if (cmd.norm) begin
      m_nxt = m_r << 1;
      x_nxt = x_r - EW'(1);
    end
    if (cmd.mul) begin
      sc_nxt = sc_r + 1'b1;
      if (sum10[SW]) begin
        m_nxt = sum10[SW:1];
        x_nxt = x_r + EW'(sh10) + EW'(1);
      end else begin
        m_nxt = sum10[SW-1:0];
        x_nxt = x_r + EW'(sh10);
      end
    end
    if (cmd.rnd) begin
      man_nxt = r_man;
      err_nxt = r_err;
    end
    if (cmd.div_clr) begin
      rem_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      quot_nxt = {quot_r[MW-CW-1:0], dq};
      rem_nxt  = dr[3:0];
      cnt_nxt  = cnt_r + 1'b1;
    end
    if (cmd.commit) begin
      man_nxt = quot_r;
      sc_nxt  = sc_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r  <= 1'b0;
      zero_r <= 1'b0;
      sc_r   <= '0;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else begin
      err_r  <= err_nxt;
      zero_r <= zero_nxt;
      sc_r   <= sc_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    x_r    <= x_nxt;
    neg_r  <= neg_nxt;
    man_r  <= man_nxt;
    quot_r <= quot_nxt;
  end

  // result register; fields forced to zero on error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_error    <= 1'b0;
      out_mantissa <= '0;
      out_scale    <= '0;
      out_negative <= 1'b0;
    end else if (cmd.out_load) begin
      out_error    <= err_r;
      out_mantissa <= err_r ? '0 : man_r;
      out_scale    <= err_r ? '0 : sc_r;
      out_negative <= err_r ? 1'b0 : neg_r;
    end
  end

  always_comb begin
    sts.err      = err_r;
    sts.zero     = zero_r;
    sts.m_top    = m_r[SW-1];
    sts.lt_one   = x_r < -$signed(EW'(SW-1));
    sts.frac_big = frac_big;
    sts.sc_max   = sc_r == f2d_pkg::SC_W'(f2d_pkg::MAX_SCALE);
    sts.sc_zero  = sc_r == '0;
    sts.rem_zero = rem_r == '0;
    sts.div_last = cnt_r == 2'(f2d_pkg::NCHUNK - 1);
  end

`ifndef SYNTHESIS
  a_sc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= f2d_pkg::SC_W'(f2d_pkg::MAX_SCALE))
    else $error("scale beyond limit");
  a_mul_norm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> m_r[SW-1])
    else $error("x10 step left significand unnormalized");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_error |-> (out_mantissa == '0 && out_scale == '0 && !out_negative))
    else $error("error word carries nonzero fields");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/f2d_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// f2d_ctrl
// Sequencer for the converter: normalize, x10 loops, rounding, zero strip.
// ----------------------------------------------------------------------------
module f2d_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire f2d_pkg::status_t sts,
  output f2d_pkg::cmd_t         cmd
);

  f2d_pkg::state_t state_r, state_nxt;
  logic            ovld_r, ovld_nxt;
  logic            slot_free;

  assign slot_free = !ovld_r || out_ready;
  assign in_ready  = state_r == f2d_pkg::ST_IDLE;
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      f2d_pkg::ST_IDLE:  if (in_valid) state_nxt = f2d_pkg::ST_NORM;
      f2d_pkg::ST_NORM: begin
        if (sts.err || sts.zero)  state_nxt = f2d_pkg::ST_FIN;
        else if (sts.m_top)       state_nxt = f2d_pkg::ST_MUL1;
      end
      f2d_pkg::ST_MUL1:  if (sts.sc_max || !sts.lt_one) state_nxt = f2d_pkg::ST_MUL2;
      f2d_pkg::ST_MUL2:  if (sts.sc_max || !sts.frac_big) state_nxt = f2d_pkg::ST_RND;
      f2d_pkg::ST_RND:   state_nxt = f2d_pkg::ST_CHK;
      f2d_pkg::ST_CHK: begin
        if (sts.err || sts.sc_zero) state_nxt = f2d_pkg::ST_FIN;
        else                        state_nxt = f2d_pkg::ST_DIV;
      end
      f2d_pkg::ST_DIV:   if (sts.div_last) state_nxt = f2d_pkg::ST_STRIP;
      f2d_pkg::ST_STRIP: begin
        if (sts.rem_zero) state_nxt = f2d_pkg::ST_CHK;
        else              state_nxt = f2d_pkg::ST_FIN;
      end
      f2d_pkg::ST_FIN:   if (slot_free) state_nxt = f2d_pkg::ST_IDLE;
      default:           state_nxt = f2d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    ovld_nxt = ovld_r && !out_ready;
    unique case (state_r)
      f2d_pkg::ST_IDLE:  cmd.load = in_valid;
      f2d_pkg::ST_NORM:  cmd.norm = !sts.err && !sts.zero && !sts.m_top;
      f2d_pkg::ST_MUL1:  cmd.mul = !sts.sc_max && sts.lt_one;
      f2d_pkg::ST_MUL2:  cmd.mul = !sts.sc_max && sts.frac_big;
      f2d_pkg::ST_RND:   cmd.rnd = 1'b1;
      f2d_pkg::ST_CHK:   cmd.div_clr = !sts.err && !sts.sc_zero;
      f2d_pkg::ST_DIV:   cmd.div_step = 1'b1;
      f2d_pkg::ST_STRIP: cmd.commit = sts.rem_zero;
      f2d_pkg::ST_FIN: begin
        cmd.out_load = slot_free;
        if (slot_free) ovld_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= f2d_pkg::ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_ready) |-> !cmd.out_load)
    else $error("result word overwritten while stalled");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == f2d_pkg::ST_NORM)
    else $error("load did not start conversion");
  a_commit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (sts.rem_zero && !sts.sc_zero))
    else $error("strip commit without zero remainder");
`endif

endmodule
`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the binary32 to decimal converter. A directed table covers
// zeros, specials, range limits and tiny values. Random words follow, then a
// stretch with no idling. Every result is checked against a double-precision
// predictor built from the float pattern.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic        error;
    logic [63:0] mantissa;
    logic [4:0]  scale;
    logic        negative;
  } decimal_t;

  typedef struct {
    logic [31:0] bits;
    bit          typed;     // expected value typed in below
    decimal_t    want;
  } vec_t;

  localparam real TWO52 = 4503599627370496.0;
  localparam real TWO64 = 18446744073709551616.0;
  localparam int  WDOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_float_bits;
  logic        out_valid;
  logic        out_ready;
  logic        out_error;
  logic [63:0] out_mantissa;
  logic [4:0]  out_scale;
  logic        out_negative;

  decimal_t pending_dec[$];
  int       fail_cnt  = 0;
  int       out_cnt   = 0;
  int       idle_cnt  = 0;
  bit       quiet     = 1'b0;
  bit       sending   = 1'b1;

  always #6 clk = ~clk;

  float_to_decimal96_convert_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_float_bits(in_float_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_error    (out_error),
    .out_mantissa (out_mantissa),
    .out_scale    (out_scale),
    .out_negative (out_negative)
  );

  // binary32 magnitude widened to a double, built from the bit fields
  function automatic real widen_float(input logic [30:0] mag);
    logic [63:0] db;
    logic [22:0] frac;
    int          msb;
    frac = mag[22:0];
    db   = '0;
    if (mag[30:23] != 8'd0) begin
      db[62:52] = 11'(int'(mag[30:23]) - 127 + 1023);
      db[51:0]  = {frac, 29'd0};
    end else begin
      msb = 0;
      for (int i = 0; i < 23; i++) if (frac[i]) msb = i;
      db[62:52] = 11'(msb - 149 + 1023);
      db[51:0]  = 52'({29'd0, frac} << (52 - msb));
    end
    return $bitstoreal(db);
  endfunction

  function automatic real floor_pos(input real x);
    longint t;
    if (x >= TWO52) return x;
    t = longint'(x);
    if (real'(t) > x) t--;
    return real'(t);
  endfunction

  // integer-valued double below 2^64 to unsigned
  function automatic logic [63:0] whole_to_u64(input real x);
    logic [63:0] db;
    logic [63:0] sig;
    int          e;
    if (x == 0.0) return '0;
    db  = $realtobits(x);
    e   = int'(db[62:52]) - 1075;
    sig = {11'd0, 1'b1, db[51:0]};
    return (e >= 0) ? (sig << e) : (sig >> (-e));
  endfunction

  function automatic bit same_dec(input decimal_t a, input decimal_t b);
    return a.error === b.error && a.mantissa === b.mantissa &&
           a.scale === b.scale && a.negative === b.negative;
  endfunction

  function automatic decimal_t predict_decimal(input logic [31:0] bits);
    decimal_t    r;
    logic [30:0] mag;
    real         d;
    real         t;
    logic [63:0] tu;
    int          sc;
    mag = bits[30:0];
    r   = '{1'b0, 64'd0, 5'd0, 1'b0};
    if (mag > f2d_pkg::MAG_LIMIT) begin
      r.error = 1'b1;
      return r;
    end
    if (mag == 31'd0) begin
      r.negative = bits[31];
      return r;
    end
    d  = widen_float(mag);
    sc = 0;
    while (sc < f2d_pkg::MAX_SCALE && d < 1.0) begin
      d = d * 10.0;
      sc++;
    end
    while (sc < f2d_pkg::MAX_SCALE && (d - floor_pos(d)) > 1e-10) begin
      d = d * 10.0;
      sc++;
    end
    if (d < TWO52) begin
      t  = floor_pos(d);
      tu = whole_to_u64(t);
      if ((d - t) > 0.5 || ((d - t) == 0.5 && tu[0])) t = t + 1.0;
      d = t;
    end
    if (d >= TWO64) begin
      r.error = 1'b1;
      return r;
    end
    r.mantissa = whole_to_u64(d);
    while (sc > 0 && r.mantissa % 10 == 0) begin
      r.mantissa = r.mantissa / 10;
      sc--;
    end
    r.scale    = 5'(sc);
    r.negative = bits[31];
    return r;
  endfunction

  // monitor: record accepted words, check results, stop the run if nothing moves for too long
  always @(posedge clk) begin
    decimal_t w;
    if (rst_n) begin
      if (in_valid && in_ready) pending_dec.push_back(predict_decimal(in_float_bits));
      if (out_valid && out_ready) begin
        out_cnt++;
        if (pending_dec.size() == 0) begin
          $display("%0t: unexpected result err=%0b man=%0d sc=%0d neg=%0b", $time,
                   out_error, out_mantissa, out_scale, out_negative);
          fail_cnt++;
        end else begin
          w = pending_dec.pop_front();
          if (w.error !== out_error || w.mantissa !== out_mantissa ||
              w.scale !== out_scale || w.negative !== out_negative) begin
            $display("%0t: mismatch exp err=%0b man=%0d sc=%0d neg=%0b", $time,
                     w.error, w.mantissa, w.scale, w.negative);
            $display("%0t:          got err=%0b man=%0d sc=%0d neg=%0b", $time,
                     out_error, out_mantissa, out_scale, out_negative);
            fail_cnt++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver side
  initial begin
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    while (sending || pending_dec.size() != 0) begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (out_cnt >= 80 && out_cnt < 82) begin
        // long hold so the result register and sequencer both back up
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk iff out_cnt >= 82);
      end else begin
        out_ready <= $urandom_range(0, 2) != 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    out_ready <= 1'b1;
  end

  task automatic send_word(input logic [31:0] bits);
    in_valid      <= 1'b1;
    in_float_bits <= bits;
    @(posedge clk iff in_ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] b;
    b = $urandom;
    case ($urandom_range(0, 9))
      0, 1:    ;                                               // any pattern
      2, 3, 4: b[30:23] = 8'($urandom_range(100, 190));        // ordinary range
      5, 6:    begin                                           // short fractions
        b[30:23] = 8'($urandom_range(118, 150));
        b[22:0]  = b[22:0] & (23'h7FFFFF << $urandom_range(10, 22));
      end
      7:       begin                                           // subnormals
        b[30:23] = 8'd0;
        b[22:0]  = b[22:0] >> $urandom_range(0, 22);
      end
      8:       b[30:23] = 8'($urandom_range(187, 224));        // near the 2^64 and 2^96 limits
      default: b[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'd0;
    endcase
    return b;
  endfunction

  vec_t dir_vecs[] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, 64'd0, 5'd0, 1'b0}},   // +0
    '{32'h8000_0000, 1'b1, '{1'b0, 64'd0, 5'd0, 1'b1}},   // -0
    '{32'h7F80_0000, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0}},   // +inf
    '{32'hFF80_0000, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0}},   // -inf
    '{32'h7FC0_0000, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0}},   // NaN
    '{32'hFFFF_FFFF, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0}},   // NaN, all ones
    '{32'h6F80_0001, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0}},   // just above 2^96
    '{32'h6F80_0000, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0}},   // exactly 2^96
    '{32'h7F7F_FFFF, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0}},   // max finite
    '{32'h5F80_0000, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0}},   // 2^64
    '{32'h3F80_0000, 1'b1, '{1'b0, 64'd1, 5'd0, 1'b0}},   // 1.0
    '{32'h4120_0000, 1'b1, '{1'b0, 64'd10, 5'd0, 1'b0}},  // 10.0
    '{32'hBF00_0000, 1'b1, '{1'b0, 64'd5, 5'd1, 1'b1}},   // -0.5
    '{32'h5F7F_FFFF, 1'b0, '{1'b0, 64'd0, 5'd0, 1'b0}},   // largest below 2^64
    '{32'h0000_0001, 1'b0, '{1'b0, 64'd0, 5'd0, 1'b0}},   // smallest subnormal
    '{32'h807F_FFFF, 1'b0, '{1'b0, 64'd0, 5'd0, 1'b0}},   // largest subnormal, negative
    '{32'h0080_0000, 1'b0, '{1'b0, 64'd0, 5'd0, 1'b0}},   // smallest normal
    '{32'h3DCC_CCCD, 1'b0, '{1'b0, 64'd0, 5'd0, 1'b0}},   // 0.1f
    '{32'h2EDB_E6FF, 1'b0, '{1'b0, 64'd0, 5'd0, 1'b0}},   // about 1e-10
    '{32'h4B7F_FFFF, 1'b0, '{1'b0, 64'd0, 5'd0, 1'b0}},   // 2^24 - 1
    '{32'hC2F6_E979, 1'b0, '{1'b0, 64'd0, 5'd0, 1'b0}},   // -123.456
    '{32'h3EAA_AAAB, 1'b0, '{1'b0, 64'd0, 5'd0, 1'b0}}    // 1/3, a long fraction
  };

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_float_bits <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_vecs[i]) begin
      if (dir_vecs[i].typed &&
          !same_dec(predict_decimal(dir_vecs[i].bits), dir_vecs[i].want)) begin
        $display("%0t: table row %0d disagrees with prediction", $time, i);
        fail_cnt++;
      end
      send_word(dir_vecs[i].bits);
    end
    for (int n = 0; n < 600; n++) begin
      if (n == 300) begin
        // drain completely before going on
        in_valid <= 1'b0;
        @(posedge clk iff pending_dec.size() == 0);
      end
      if (n == 540) quiet = 1'b1;
      send_word(rand_float());
    end
    in_valid <= 1'b0;
    sending = 1'b0;
    @(posedge clk iff pending_dec.size() == 0);
    repeat (250) @(posedge clk);
    if (fail_cnt == 0 && pending_dec.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> float_to_decimal96_convert_top.f
hw/rtl/f2d_pkg.sv
hw/rtl/f2d_datapath.sv
hw/rtl/f2d_ctrl.sv
hw/rtl/float_to_decimal96_convert_top.sv
dv/tb.sv
